// ===== rtl/assert_macros.svh =====
// Assertion macros for the port-level checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GVG_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
        else $error("gvg assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define GVG_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
        else $error("gvg assertion failed");

`endif

// ===== rtl/gvg_pkg.sv =====
// Types, codes and constants of the grid variance ground classifier.
package gvg_pkg;

    // Grid size defaults
    localparam int MAX_ROWS_DEF = 256;
    localparam int MAX_COLS_DEF = 256;

    // Field widths
    localparam int COORD_W    = 16;
    localparam int CSIZE_W    = 15;
    localparam int THR_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int CNT_W      = 16;
    localparam int ZSUM_W     = 32;
    localparam int ZSQ_W      = 48;

    // Item kinds
    localparam logic [1:0] KIND_ACC  = 2'd0;
    localparam logic [1:0] KIND_CLS  = 2'd1;
    localparam logic [1:0] KIND_CLR  = 2'd2;

    // Result status codes
    localparam logic [2:0] STATUS_ACCUMULATED = 3'd0;
    localparam logic [2:0] STATUS_DROPPED     = 3'd1;
    localparam logic [2:0] STATUS_GROUND      = 3'd2;
    localparam logic [2:0] STATUS_NOT_GROUND  = 3'd3;
    localparam logic [2:0] STATUS_CLEARED     = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_X      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_Y      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_Y      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_EN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_HEIGHT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 3'd7;

    // Configuration reset values
    localparam logic signed [COORD_W-1:0] MIN_X_RST      = -16'sd5000;
    localparam logic signed [COORD_W-1:0] MAX_X_RST      = 16'sd20000;
    localparam logic signed [COORD_W-1:0] MIN_Y_RST      = -16'sd10000;
    localparam logic signed [COORD_W-1:0] MAX_Y_RST      = 16'sd10000;
    localparam logic                      CLIP_EN_RST    = 1'b1;
    localparam logic signed [COORD_W-1:0] MAX_HEIGHT_RST = 16'sd1000;
    localparam logic [CSIZE_W-1:0]        CELL_SIZE_RST  = 15'd100;
    localparam logic [THR_W-1:0]          THRESHOLD_RST  = 32'd300000;

    // Lower z limit of the height band
    localparam logic signed [COORD_W-1:0] Z_FLOOR = -16'sd2000;

    // Saturation point of a cell's count
    localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;

    // Input item
    typedef struct packed {
        logic [1:0]                kind;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
    } cmd_t;

    // Result item
    typedef struct packed {
        logic [2:0] status;
        logic [7:0] cell_row;
        logic [7:0] cell_col;
    } result_t;

    // One grid cell as kept in the cell memory
    typedef struct packed {
        logic [CNT_W-1:0]         count;
        logic signed [ZSUM_W-1:0] zsum;
        logic [ZSQ_W-1:0]         zsq;
    } cell_t;

    // Divider result
    typedef struct packed {
        logic                done;
        logic [COORD_W-1:0]  quot;
        logic [CSIZE_W-1:0]  rem;
    } div_res_t;

    // Variance test result
    typedef struct packed {
        logic done;
        logic ground;
    } var_res_t;

endpackage

// ===== rtl/gvg_divider.sv =====
// Restoring divider, one quotient bit per cycle, for the grid cell index.
module gvg_divider
    import gvg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [COORD_W-1:0] dividend,
    input  logic [CSIZE_W-1:0] divisor,
    output div_res_t           res
);

    localparam int CNT_BITS = $clog2(COORD_W);
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(COORD_W - 1);

    logic                running_reg;
    logic                done_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic [COORD_W-1:0]  dvd_reg;
    logic [CSIZE_W-1:0]  rem_reg;
    logic [CSIZE_W-1:0]  dsr_reg;

    logic [COORD_W-1:0]  rem_shift;
    logic [COORD_W:0]    trial;
    logic                q_bit;

    // Shift in the next dividend bit and try a subtract
    assign rem_shift = {rem_reg, dvd_reg[COORD_W-1]};
    assign trial     = {1'b0, rem_shift} - {2'b00, dsr_reg};
    assign q_bit     = !trial[COORD_W];

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            done_reg    <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                running_reg <= 1'b1;
                cnt_reg     <= '0;
            end
            else if (running_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    running_reg <= 1'b0;
                    done_reg    <= 1'b1;
                end
            end
        end
    end

    // Datapath: dividend register collects the quotient bits
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (running_reg)
        begin
            dvd_reg <= {dvd_reg[COORD_W-2:0], q_bit};
            rem_reg <= q_bit ? trial[CSIZE_W-1:0] : rem_shift[CSIZE_W-1:0];
        end
    end

    assign res.done = done_reg;
    assign res.quot = dvd_reg;
    assign res.rem  = rem_reg;

endmodule

// ===== rtl/gvg_variance.sv =====
// Cell variance test n*sumsq - sum^2 < threshold*n^2 on one shared multiplier.
module gvg_variance
    import gvg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  cell_t            cell_in,
    input  logic [THR_W-1:0] threshold,
    output var_res_t         res
);

    localparam logic [2:0] STEP_NN   = 3'd0;
    localparam logic [2:0] STEP_SS   = 3'd1;
    localparam logic [2:0] STEP_NQLO = 3'd2;
    localparam logic [2:0] STEP_NQHI = 3'd3;
    localparam logic [2:0] STEP_TN2  = 3'd4;
    localparam logic [2:0] STEP_SUB  = 3'd5;
    localparam logic [2:0] STEP_CMP  = 3'd6;
    localparam int HALF_W = ZSQ_W / 2;

    logic               running_reg;
    logic [2:0]         step_reg;
    logic               done_reg;
    logic               ground_reg;
    logic [CNT_W-1:0]   n_reg;
    logic [ZSUM_W-1:0]  mag_reg;
    logic [ZSQ_W-1:0]   zsq_reg;
    logic [31:0]        n2_reg;
    logic [63:0]        sq_reg;
    logic [63:0]        acc_reg;
    logic [63:0]        prod_reg;

    logic [31:0]        a_op;
    logic [31:0]        b_op;
    logic               mul_en;
    logic [ZSUM_W-1:0]  zsum_u;

    assign zsum_u = cell_in.zsum;

    // Multiplier operand selection per step
    always_comb
    begin
        a_op   = '0;
        b_op   = '0;
        mul_en = running_reg;
        unique case (step_reg)
            STEP_NN:
            begin
                a_op = {16'd0, n_reg};
                b_op = {16'd0, n_reg};
            end
            STEP_SS:
            begin
                a_op = mag_reg;
                b_op = mag_reg;
            end
            STEP_NQLO:
            begin
                a_op = {16'd0, n_reg};
                b_op = {8'd0, zsq_reg[HALF_W-1:0]};
            end
            STEP_NQHI:
            begin
                a_op = {16'd0, n_reg};
                b_op = {8'd0, zsq_reg[ZSQ_W-1:HALF_W]};
            end
            STEP_TN2:
            begin
                a_op = threshold;
                b_op = n2_reg;
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    // Sequencer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            step_reg    <= STEP_NN;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                running_reg <= 1'b1;
                step_reg    <= STEP_NN;
            end
            else if (running_reg)
            begin
                step_reg <= step_reg + 3'd1;
                if (step_reg == STEP_CMP)
                begin
                    running_reg <= 1'b0;
                    done_reg    <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg   <= cell_in.count;
            zsq_reg <= cell_in.zsq;
            mag_reg <= zsum_u[ZSUM_W-1] ? (~zsum_u + 1'b1) : zsum_u;
        end
        if (mul_en)
        begin
            prod_reg <= a_op * b_op;
        end
        if (running_reg)
        begin
            unique case (step_reg)
                STEP_SS:   n2_reg  <= prod_reg[31:0];
                STEP_NQLO: sq_reg  <= prod_reg;
                STEP_NQHI: acc_reg <= prod_reg;
                STEP_TN2:  acc_reg <= acc_reg + {prod_reg[63-HALF_W:0], {HALF_W{1'b0}}};
                STEP_SUB:  acc_reg <= acc_reg - sq_reg;
                STEP_CMP:  ground_reg <= acc_reg < prod_reg;
                default:   ;
            endcase
        end
    end

    assign res.done   = done_reg;
    assign res.ground = ground_reg;

endmodule

// ===== rtl/grid_variance_ground_classifier.sv =====
// Grid variance ground classifier: top level with cell memory and sequencer.
//
// One item at a time; busy is high from acceptance until its result strobe.
// A point that fails the region, height, kind or cell-size screen answers
// dropped from the check state. Otherwise the grid cell index comes from
// two bit-serial dividers, one per axis, and is checked against the grid
// in the locate state, where a point off the grid answers dropped.
// Then come a registered memory read and an update: an accumulate, or a
// classify into an empty cell, answers from the update; any other classify
// runs on through the shared 32x32 multiplier and answers when it is done.
// A clear item sweeps the cell memory one entry per cycle, all
// MAX_ROWS*MAX_COLS entries (65536 at the default size), and answers at the
// end of the sweep. The same sweep runs after reset with busy high;
// configuration writes are taken at any time, also during the sweep. The
// result strobe done is high for one cycle and cannot be held off.
module grid_variance_ground_classifier
    import gvg_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEF,
    parameter int MAX_COLS = MAX_COLS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  cmd_t                  cmd,
    output logic                  done,
    output result_t               result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(DEPTH - 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CHECK  = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_LOCATE = 3'd3;
    localparam logic [2:0] ST_READ   = 3'd4;
    localparam logic [2:0] ST_UPDATE = 3'd5;
    localparam logic [2:0] ST_VAR    = 3'd6;
    localparam logic [2:0] ST_SWEEP  = 3'd7;

    // Configuration registers
    logic signed [COORD_W-1:0] min_x_reg;
    logic signed [COORD_W-1:0] max_x_reg;
    logic signed [COORD_W-1:0] min_y_reg;
    logic signed [COORD_W-1:0] max_y_reg;
    logic                      clip_en_reg;
    logic signed [COORD_W-1:0] max_height_reg;
    logic [CSIZE_W-1:0]        cell_size_reg;
    logic [THR_W-1:0]          threshold_reg;

    // Sequencer and datapath registers
    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    cmd_t              item_reg;
    logic [30:0]       zz_reg;
    logic [7:0]        row_reg;
    logic [7:0]        col_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic              clr_report_reg;
    cell_t             rd_reg;
    logic              done_reg;
    result_t           result_reg;

    // Cell memory
    cell_t mem [DEPTH];

    logic              emit;
    result_t           emit_res;
    logic              accept;
    logic              check_ok;
    logic              locate_ok;
    logic [COORD_W:0]  dx_full;
    logic [COORD_W:0]  dy_full;
    logic signed [31:0] zz_full;
    logic [ADDR_W-1:0] addr_calc;
    logic              cell_full;
    logic              cell_empty;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    cell_t             mem_wdata;
    cell_t             upd_cell;
    logic              div_start;
    logic              var_start;
    div_res_t          div_x_res;
    div_res_t          div_y_res;
    var_res_t          var_res;

    assign busy   = state_reg != ST_IDLE;
    assign accept = start && !busy;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_x_reg      <= MIN_X_RST;
            max_x_reg      <= MAX_X_RST;
            min_y_reg      <= MIN_Y_RST;
            max_y_reg      <= MAX_Y_RST;
            clip_en_reg    <= CLIP_EN_RST;
            max_height_reg <= MAX_HEIGHT_RST;
            cell_size_reg  <= CELL_SIZE_RST;
            threshold_reg  <= THRESHOLD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MIN_X:      min_x_reg      <= cfg_data[COORD_W-1:0];
                CFG_MAX_X:      max_x_reg      <= cfg_data[COORD_W-1:0];
                CFG_MIN_Y:      min_y_reg      <= cfg_data[COORD_W-1:0];
                CFG_MAX_Y:      max_y_reg      <= cfg_data[COORD_W-1:0];
                CFG_CLIP_EN:    clip_en_reg    <= cfg_data[0];
                CFG_MAX_HEIGHT: max_height_reg <= cfg_data[COORD_W-1:0];
                CFG_CELL_SIZE:  cell_size_reg  <= cfg_data[CSIZE_W-1:0];
                CFG_THRESHOLD:  threshold_reg  <= cfg_data[THR_W-1:0];
                default:        ;
            endcase
        end
    end

    // Cell-size, region, height band and kind screen
    assign check_ok = (cell_size_reg != '0)
                   && (item_reg.kind == KIND_ACC || item_reg.kind == KIND_CLS)
                   && (item_reg.point_x >= min_x_reg) && (item_reg.point_x <= max_x_reg)
                   && (item_reg.point_y >= min_y_reg) && (item_reg.point_y <= max_y_reg)
                   && (!clip_en_reg || ((item_reg.point_z >= Z_FLOOR)
                                        && (item_reg.point_z <= max_height_reg)));

    // Offsets into the region, non-negative once the screen passes
    assign dx_full   = {item_reg.point_x[COORD_W-1], item_reg.point_x}
                     - {min_x_reg[COORD_W-1], min_x_reg};
    assign dy_full   = {item_reg.point_y[COORD_W-1], item_reg.point_y}
                     - {min_y_reg[COORD_W-1], min_y_reg};
    assign zz_full   = item_reg.point_z * item_reg.point_z;
    assign div_start = (state_reg == ST_CHECK) && check_ok;

    gvg_divider u_div_x
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dx_full[COORD_W-1:0]),
        .divisor  (cell_size_reg),
        .res      (div_x_res)
    );

    gvg_divider u_div_y
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dy_full[COORD_W-1:0]),
        .divisor  (cell_size_reg),
        .res      (div_y_res)
    );

    // Grid bounds: the boundary row sits exactly on max with no remainder
    assign locate_ok = ({16'd0, div_x_res.quot} < 32'(MAX_ROWS))
                    && ({16'd0, div_y_res.quot} < 32'(MAX_COLS))
                    && !((item_reg.point_x == max_x_reg) && (div_x_res.rem == '0))
                    && !((item_reg.point_y == max_y_reg) && (div_y_res.rem == '0));
    assign addr_calc = ADDR_W'(div_x_res.quot) * ADDR_W'(MAX_COLS)
                     + ADDR_W'(div_y_res.quot);

    // Cell update
    assign cell_full      = rd_reg.count == COUNT_MAX;
    assign cell_empty     = rd_reg.count == '0;
    assign upd_cell.count = rd_reg.count + 1'b1;
    assign upd_cell.zsum  = rd_reg.zsum
                          + {{(ZSUM_W-COORD_W){item_reg.point_z[COORD_W-1]}}, item_reg.point_z};
    assign upd_cell.zsq   = rd_reg.zsq + {17'd0, zz_reg};

    assign mem_we    = (state_reg == ST_SWEEP)
                    || ((state_reg == ST_UPDATE) && (item_reg.kind == KIND_ACC) && !cell_full);
    assign mem_waddr = (state_reg == ST_SWEEP) ? clr_addr_reg : addr_reg;
    assign mem_wdata = (state_reg == ST_SWEEP) ? cell_t'('0) : upd_cell;
    assign var_start = (state_reg == ST_UPDATE) && (item_reg.kind == KIND_CLS) && !cell_empty;

    gvg_variance u_var
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (var_start),
        .cell_in   (rd_reg),
        .threshold (threshold_reg),
        .res       (var_res)
    );

    // Sequencer next state and result
    always_comb
    begin
        state_next        = state_reg;
        emit              = 1'b0;
        emit_res.status   = STATUS_DROPPED;
        emit_res.cell_row = '0;
        emit_res.cell_col = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = (cmd.kind == KIND_CLR) ? ST_SWEEP : ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (check_ok)
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                if (div_x_res.done && div_y_res.done)
                begin
                    state_next = ST_LOCATE;
                end
            end
            ST_LOCATE:
            begin
                if (locate_ok)
                begin
                    state_next = ST_READ;
                end
                else
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (item_reg.kind == KIND_CLS && !cell_empty)
                begin
                    state_next = ST_VAR;
                end
                else
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                    if (item_reg.kind == KIND_ACC && !cell_full)
                    begin
                        emit_res.status   = STATUS_ACCUMULATED;
                        emit_res.cell_row = row_reg;
                        emit_res.cell_col = col_reg;
                    end
                end
            end
            ST_VAR:
            begin
                if (var_res.done)
                begin
                    emit              = 1'b1;
                    state_next        = ST_IDLE;
                    emit_res.status   = var_res.ground ? STATUS_GROUND : STATUS_NOT_GROUND;
                    emit_res.cell_row = row_reg;
                    emit_res.cell_col = col_reg;
                end
            end
            ST_SWEEP:
            begin
                if (clr_addr_reg == ADDR_LAST)
                begin
                    state_next      = ST_IDLE;
                    emit            = clr_report_reg;
                    emit_res.status = STATUS_CLEARED;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_SWEEP;
            clr_addr_reg   <= '0;
            clr_report_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= emit;
            if (accept && cmd.kind == KIND_CLR)
            begin
                clr_addr_reg   <= '0;
                clr_report_reg <= 1'b1;
            end
            else if (state_reg == ST_SWEEP)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= cmd;
        end
        if (state_reg == ST_CHECK)
        begin
            zz_reg <= zz_full[30:0];
        end
        if (state_reg == ST_LOCATE)
        begin
            addr_reg <= addr_calc;
            row_reg  <= div_x_res.quot[7:0];
            col_reg  <= div_y_res.quot[7:0];
        end
        if (emit)
        begin
            result_reg <= emit_res;
        end
    end

    // Cell memory ports: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_READ)
        begin
            rd_reg <= mem[addr_reg];
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== rtl/gvg_checker.sv =====
// Port-level assertions for the classifier and their bind to the top level.
`include "assert_macros.svh"

module gvg_checker
    import gvg_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input logic    done,
    input result_t result
);

    // Status codes stay within the defined set
    `GVG_ASSERT_IMP(a_status_code, clk, rst_n, done, result.status <= STATUS_CLEARED)

    // Dropped and cleared results carry no cell position
    `GVG_ASSERT_IMP(a_no_cell, clk, rst_n,
        done && (result.status == STATUS_DROPPED || result.status == STATUS_CLEARED),
        result.cell_row == 8'd0 && result.cell_col == 8'd0)

    // An accepted item keeps the block busy in the next cycle
    `GVG_ASSERT_NXT(a_busy_after_accept, clk, rst_n, start && !busy, busy)

    // One item in flight: results never come in adjacent cycles
    `GVG_ASSERT_NXT(a_done_spacing, clk, rst_n, done, !done)

endmodule

bind grid_variance_ground_classifier gvg_checker u_gvg_checker
(
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

// ===== tb/gvg_checker.sv =====
// Checker for the grid variance ground classifier: predicts every result and compares it.
module gvg_tb_checker
    import gvg_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEF,
    parameter int MAX_COLS = MAX_COLS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  cmd_t                  cmd,
    input  logic                  done,
    input  result_t               result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    pending,
    output int                    fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the configuration registers
    logic signed [COORD_W-1:0] lo_x;
    logic signed [COORD_W-1:0] hi_x;
    logic signed [COORD_W-1:0] lo_y;
    logic signed [COORD_W-1:0] hi_y;
    logic signed [COORD_W-1:0] z_top;
    logic                      clip_on;
    logic [CSIZE_W-1:0]        cell_len;
    logic [THR_W-1:0]          var_limit;

    // Grid contents; a missing key is an empty cell
    cell_t   grid_cells[int];
    result_t expected_results[$];
    int      mismatches = 0;

    assign fail_count = mismatches;

    task automatic report(input string msg);
        $display("%0t ns  mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // Grid position of a point, or 0 when the point fails the screen or falls off the grid
    function automatic bit grid_position(input cmd_t c, output int row, output int col);
        longint x, y, z, lx, hx, ly, hy, zt, cs;
        row = 0;
        col = 0;
        x  = $signed(c.point_x);
        y  = $signed(c.point_y);
        z  = $signed(c.point_z);
        lx = lo_x;
        hx = hi_x;
        ly = lo_y;
        hy = hi_y;
        zt = z_top;
        cs = cell_len;
        if (cs == 0)
            return 1'b0;
        if (x < lx || x > hx || y < ly || y > hy)
            return 1'b0;
        if (clip_on && (z < Z_FLOOR || z > zt))
            return 1'b0;
        row = int'((x - lx) / cs);
        col = int'((y - ly) / cs);
        // boundary row/column of the ceiling-sized grid
        if (row >= (hx - lx + cs - 1) / cs || col >= (hy - ly + cs - 1) / cs)
            return 1'b0;
        if (row >= MAX_ROWS || col >= MAX_COLS)
            return 1'b0;
        return 1'b1;
    endfunction

    // Outcome of one item; updates the grid as the block would
    function automatic result_t grid_outcome(input cmd_t c);
        result_t              r;
        int                   row, col, key;
        cell_t                g;
        longint               z, sz;
        longint unsigned      n, mag, num;
        r.status   = STATUS_DROPPED;
        r.cell_row = '0;
        r.cell_col = '0;
        if (c.kind == KIND_CLR) begin
            grid_cells.delete();
            r.status = STATUS_CLEARED;
        end
        else if ((c.kind == KIND_ACC || c.kind == KIND_CLS) && grid_position(c, row, col)) begin
            key = row * MAX_COLS + col;
            if (grid_cells.exists(key))
                g = grid_cells[key];
            else
                g = '0;
            z = $signed(c.point_z);
            if (c.kind == KIND_ACC) begin
                // a saturated count leaves the entry untouched
                if (g.count != COUNT_MAX) begin
                    g.count = g.count + 1'b1;
                    g.zsum  = g.zsum + 32'(z);
                    g.zsq   = g.zsq + 48'(z * z);
                    grid_cells[key] = g;
                    r.status = STATUS_ACCUMULATED;
                end
            end
            else if (g.count != 0) begin
                // n*sumsq - sum^2 compared against threshold*n^2 via integer floor
                n   = 64'(g.count);
                sz  = $signed(g.zsum);
                mag = (sz < 0) ? 64'(-sz) : 64'(sz);
                num = n * 64'(g.zsq) - mag * mag;
                r.status = ((num / (n * n)) < 64'(var_limit)) ? STATUS_GROUND
                                                             : STATUS_NOT_GROUND;
            end
            if (r.status != STATUS_DROPPED) begin
                r.cell_row = row[7:0];
                r.cell_col = col[7:0];
            end
        end
        return r;
    endfunction

    // Watch config writes, item transfers and result strobes
    always @(posedge clk or negedge rst_n) begin : watch
        result_t want;
        if (!rst_n) begin
            lo_x      = MIN_X_RST;
            hi_x      = MAX_X_RST;
            lo_y      = MIN_Y_RST;
            hi_y      = MAX_Y_RST;
            clip_on   = CLIP_EN_RST;
            z_top     = MAX_HEIGHT_RST;
            cell_len  = CELL_SIZE_RST;
            var_limit = THRESHOLD_RST;
            grid_cells.delete();
            expected_results.delete();
            pending <= 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_MIN_X:      lo_x      = cfg_data[COORD_W-1:0];
                    CFG_MAX_X:      hi_x      = cfg_data[COORD_W-1:0];
                    CFG_MIN_Y:      lo_y      = cfg_data[COORD_W-1:0];
                    CFG_MAX_Y:      hi_y      = cfg_data[COORD_W-1:0];
                    CFG_CLIP_EN:    clip_on   = cfg_data[0];
                    CFG_MAX_HEIGHT: z_top     = cfg_data[COORD_W-1:0];
                    CFG_CELL_SIZE:  cell_len  = cfg_data[CSIZE_W-1:0];
                    CFG_THRESHOLD:  var_limit = cfg_data[THR_W-1:0];
                    default: ;
                endcase
            end
            if (start && !busy)
                expected_results = {expected_results, grid_outcome(cmd)};
            if (done) begin
                if (expected_results.size() == 0) begin
                    report($sformatf("result status %0d row %0d col %0d with no item outstanding",
                                     result.status, result.cell_row, result.cell_col));
                end
                else begin
                    want = expected_results.pop_front();
                    if (result.status !== want.status)
                        report($sformatf("status %0d, expected %0d",
                                         result.status, want.status));
                    if (result.cell_row !== want.cell_row)
                        report($sformatf("cell_row %0d, expected %0d",
                                         result.cell_row, want.cell_row));
                    if (result.cell_col !== want.cell_col)
                        report($sformatf("cell_col %0d, expected %0d",
                                         result.cell_col, want.cell_col));
                end
            end
            pending <= expected_results.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top: drives items and configuration into the classifier and gives the verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import gvg_pkg::*;

    localparam int         GRID_ROWS   = MAX_ROWS_DEF;
    localparam int         GRID_COLS   = MAX_COLS_DEF;
    localparam int         PHASES      = 7;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  start     = 1'b0;
    logic                  busy;
    cmd_t                  cmd       = '0;
    logic                  done;
    result_t               result;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    int                    pending;
    int                    fail_count;

    // Configuration as last written, for shaping the points
    int cur_mnx, cur_mxx, cur_mny, cur_mxy, cur_clip, cur_mh, cur_cs;
    bit no_idle;
    // Cells that a frame concentrates on
    int n_hot;
    int hot_row[8];
    int hot_col[8];
    int hot_base[8];
    int hot_spread[8];

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    grid_variance_ground_classifier #(
        .MAX_ROWS (GRID_ROWS),
        .MAX_COLS (GRID_COLS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    gvg_tb_checker #(
        .MAX_ROWS (GRID_ROWS),
        .MAX_COLS (GRID_COLS)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .done       (done),
        .result     (result),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pending    (pending),
        .fail_count (fail_count)
    );

    function automatic int rand_between(input int lo, input int hi);
        if (hi <= lo)
            return lo;
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic int clamp16(input int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic cmd_t mk_cmd(input logic [1:0] k, input int x, input int y, input int z);
        cmd_t c;
        c.kind    = k;
        c.point_x = 16'(clamp16(x));
        c.point_y = 16'(clamp16(y));
        c.point_z = 16'(clamp16(z));
        return c;
    endfunction

    function automatic logic [31:0] pick_threshold();
        case ($urandom_range(0, 3))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'(rand_between(0, 400000));
            default: return $urandom;
        endcase
    endfunction

    // Mostly back to back or short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return rand_between(1, 3);
        if (r < 97)
            return rand_between(4, 12);
        return rand_between(13, 60);
    endfunction

    // Number of grid cells along one axis, kept within [1, limit]
    function automatic int grid_span(input int lo, input int hi, input int limit);
        int n;
        if (hi < lo || cur_cs < 1)
            return 1;
        n = (hi - lo + cur_cs - 1) / cur_cs;
        if (n < 1)
            n = 1;
        if (n > limit)
            n = limit;
        return n;
    endfunction

    // A point somewhere inside one of the hot cells
    function automatic cmd_t hot_point(input int h, input logic [1:0] k);
        int x, y, z, lo, hi;
        x  = cur_mnx + hot_row[h] * cur_cs + rand_between(0, cur_cs - 1);
        y  = cur_mny + hot_col[h] * cur_cs + rand_between(0, cur_cs - 1);
        z  = hot_base[h] + rand_between(-hot_spread[h], hot_spread[h]);
        lo = cur_clip ? int'(Z_FLOOR) : -32768;
        hi = cur_clip ? cur_mh : 32767;
        if (hi >= lo) begin
            if (z < lo)
                z = lo;
            if (z > hi)
                z = hi;
        end
        return mk_cmd(k, x, y, z);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // Write all registers; unused upper data bits carry junk
    task automatic load_config(input int mnx, input int mxx, input int mny, input int mxy,
                               input int clip, input int mh, input int cs,
                               input logic [31:0] thr);
        logic [31:0] junk;
        cur_mnx  = mnx;
        cur_mxx  = mxx;
        cur_mny  = mny;
        cur_mxy  = mxy;
        cur_clip = clip;
        cur_mh   = mh;
        cur_cs   = cs;
        junk = $urandom;
        write_reg(CFG_MIN_X, {junk[31:16], 16'(mnx)});
        junk = $urandom;
        write_reg(CFG_MAX_X, {junk[31:16], 16'(mxx)});
        junk = $urandom;
        write_reg(CFG_MIN_Y, {junk[31:16], 16'(mny)});
        junk = $urandom;
        write_reg(CFG_MAX_Y, {junk[31:16], 16'(mxy)});
        junk = $urandom;
        write_reg(CFG_CLIP_EN, {junk[31:1], 1'(clip)});
        junk = $urandom;
        write_reg(CFG_MAX_HEIGHT, {junk[31:16], 16'(mh)});
        junk = $urandom;
        write_reg(CFG_CELL_SIZE, {junk[31:15], 15'(cs)});
        write_reg(CFG_THRESHOLD, thr);
    endtask

    // One item transfer, then an optional idle gap with junk on the bus
    task automatic send_item(input cmd_t c);
        int   gap;
        cmd_t junk;
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        gap = pick_gap();
        if (gap > 0) begin
            junk.kind    = 2'($urandom);
            junk.point_x = 16'($urandom);
            junk.point_y = 16'($urandom);
            junk.point_z = 16'($urandom);
            start <= 1'b0;
            cmd   <= junk;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Block idle and every expected result seen
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy)
            @(posedge clk);
    endtask

    initial begin : stimulus
        int          p, i, h, r, n_items, rows_n, cols_n, lo, hi;
        int          mnx, mxx, mny, mxy, clip, mh, cs;
        logic [31:0] thr;
        cmd_t        c;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        // clearing sweep after reset
        wait_idle();

        // Directed items under the reset configuration
        no_idle = 1'b0;
        send_item(mk_cmd(KIND_ACC, -5000, -10000, 0));
        send_item(mk_cmd(KIND_ACC, -4901, -9901, -2000));
        send_item(mk_cmd(KIND_ACC, -4950, -9950, 1000));
        send_item(mk_cmd(KIND_ACC, -4950, -9950, -2001));
        send_item(mk_cmd(KIND_ACC, -4950, -9950, 1001));
        send_item(mk_cmd(KIND_ACC, 20000, 0, 0));
        send_item(mk_cmd(KIND_ACC, 0, 10000, 0));
        send_item(mk_cmd(KIND_ACC, -5001, 0, 0));
        send_item(mk_cmd(KIND_ACC, 0, -10001, 0));
        send_item(mk_cmd(KIND_ACC, 19999, 9999, 0));
        send_item(mk_cmd(KIND_ACC, -32768, -32768, -32768));
        send_item(mk_cmd(KIND_ACC, 32767, 32767, 32767));
        send_item(mk_cmd(KIND_CLS, -5000, -10000, 0));
        send_item(mk_cmd(KIND_CLS, 19999, 9999, 5));
        send_item(mk_cmd(KIND_CLS, 0, 0, 0));
        send_item(mk_cmd(KIND_CLS, 32767, -32768, -1));
        send_item(mk_cmd(KIND_UNUSED, 0, 0, 0));
        send_item(mk_cmd(KIND_CLR, -1, -1, -1));
        send_item(mk_cmd(KIND_CLS, 19999, 9999, 0));
        wait_idle();

        // Zero cell size drops everything
        write_reg(CFG_CELL_SIZE, 32'd0);
        send_item(mk_cmd(KIND_ACC, 0, 0, 0));
        send_item(mk_cmd(KIND_CLS, 0, 0, 0));
        wait_idle();

        // Height clipping off: full-scale z is kept
        load_config(-5000, 20000, -10000, 10000, 0, 1000, 100, 32'd300000);
        send_item(mk_cmd(KIND_ACC, 0, 0, -32768));
        send_item(mk_cmd(KIND_ACC, 0, 0, 32767));
        send_item(mk_cmd(KIND_CLS, 0, 0, 0));
        wait_idle();

        // Random frames: clear, then mostly points in a few busy cells
        for (p = 0; p < PHASES; p++) begin
            n_items = 185;
            thr     = pick_threshold();
            case (p)
                0: begin
                    mnx  = -rand_between(0, 6000);
                    mxx  = mnx + rand_between(500, 20000);
                    mny  = -rand_between(0, 12000);
                    mxy  = mny + rand_between(500, 20000);
                    clip = 1;
                    mh   = rand_between(-1500, 3000);
                    cs   = rand_between(20, 500);
                end
                1: begin
                    mnx  = -32768;
                    mxx  = 32767;
                    mny  = -32768;
                    mxy  = 32767;
                    clip = 0;
                    mh   = 32767;
                    cs   = 1;
                    thr  = 32'hFFFF_FFFF;
                end
                2: begin
                    mnx  = -32768;
                    mxx  = 32767;
                    mny  = -32768;
                    mxy  = 32767;
                    clip = 0;
                    mh   = rand_between(-32768, 32767);
                    cs   = 32767;
                    thr  = 32'd0;
                end
                3: begin
                    mnx  = rand_between(-32768, 0);
                    mxx  = rand_between(mnx, 32767);
                    mny  = rand_between(-32768, 0);
                    mxy  = rand_between(mny, 32767);
                    clip = 1;
                    mh   = 32767;
                    cs   = rand_between(1000, 8000);
                end
                4: begin
                    // empty region and an empty height band
                    mnx     = 1000;
                    mxx     = -1000;
                    mny     = -32768;
                    mxy     = 32767;
                    clip    = 1;
                    mh      = -32768;
                    cs      = 1;
                    n_items = 40;
                end
                default: begin
                    mnx  = rand_between(-32768, 32767);
                    mxx  = rand_between(-32768, 32767);
                    mny  = rand_between(-32768, 32767);
                    mxy  = rand_between(-32768, 32767);
                    if (mxx < mnx && $urandom_range(0, 4) != 0) begin
                        h   = mnx;
                        mnx = mxx;
                        mxx = h;
                    end
                    if (mxy < mny && $urandom_range(0, 4) != 0) begin
                        h   = mny;
                        mny = mxy;
                        mxy = h;
                    end
                    clip = $urandom_range(0, 1);
                    mh   = rand_between(-32768, 32767);
                    cs   = ($urandom_range(0, 1) != 0) ? rand_between(1, 64)
                                                       : rand_between(1, 32767);
                end
            endcase
            load_config(mnx, mxx, mny, mxy, clip, mh, cs, thr);

            // Pick the busy cells of this frame
            n_hot  = rand_between(1, 8);
            rows_n = grid_span(cur_mnx, cur_mxx, GRID_ROWS);
            cols_n = grid_span(cur_mny, cur_mxy, GRID_COLS);
            lo     = cur_clip ? int'(Z_FLOOR) : -32768;
            hi     = cur_clip ? cur_mh : 32767;
            for (h = 0; h < n_hot; h++) begin
                hot_row[h]  = rand_between(0, rows_n - 1);
                hot_col[h]  = rand_between(0, cols_n - 1);
                hot_base[h] = (hi >= lo) ? rand_between(lo, hi) : rand_between(-32768, 32767);
                case ($urandom_range(0, 3))
                    0:       hot_spread[h] = 0;
                    1:       hot_spread[h] = 3;
                    2:       hot_spread[h] = 400;
                    default: hot_spread[h] = 2500;
                endcase
            end
            no_idle = ($urandom_range(0, 3) == 0);

            send_item(mk_cmd(KIND_CLR, int'($signed(16'($urandom))),
                             int'($signed(16'($urandom))), int'($signed(16'($urandom)))));
            for (i = 0; i < n_items; i++) begin
                r = $urandom_range(0, 99);
                h = rand_between(0, n_hot - 1);
                if (r < 50) begin
                    c = hot_point(h, KIND_ACC);
                end
                else if (r < 75) begin
                    c = hot_point(h, KIND_CLS);
                end
                else if (r < 88) begin
                    // a point pushed onto or past one of the limits
                    c = hot_point(h, ($urandom_range(0, 1) != 0) ? KIND_CLS : KIND_ACC);
                    case ($urandom_range(0, 7))
                        0: c.point_x = 16'(clamp16(cur_mxx));
                        1: c.point_y = 16'(clamp16(cur_mxy));
                        2: c.point_x = 16'(clamp16(cur_mnx - 1));
                        3: c.point_y = 16'(clamp16(cur_mny - 1));
                        4: c.point_z = 16'(clamp16(int'(Z_FLOOR) - 1));
                        5: c.point_z = 16'(clamp16(cur_mh + 1));
                        6: c.point_x = 16'(clamp16(cur_mnx + GRID_ROWS * cur_cs));
                        default: c.point_y = 16'(clamp16(cur_mny + GRID_COLS * cur_cs));
                    endcase
                end
                else begin
                    // full-range noise, never a clear
                    case ($urandom_range(0, 2))
                        0:       c.kind = KIND_ACC;
                        1:       c.kind = KIND_CLS;
                        default: c.kind = KIND_UNUSED;
                    endcase
                    c.point_x = 16'($urandom);
                    c.point_y = 16'($urandom);
                    c.point_z = 16'($urandom);
                end
                send_item(c);
            end
            wait_idle();
        end

        // Let any stray strobe show up before the verdict
        repeat (64) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog
    initial begin
        #30ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/gvg_pkg.sv
rtl/gvg_divider.sv
rtl/gvg_variance.sv
rtl/grid_variance_ground_classifier.sv
rtl/gvg_checker.sv
tb/gvg_checker.sv
tb/tb_top.sv
